// ===== rtl/current_regulated_pwm_duty_step_assert.svh =====
// Assertion macros used by the duty stepper core module.
`ifndef CURRENT_REGULATED_PWM_DUTY_STEP_ASSERT_SVH
`define CURRENT_REGULATED_PWM_DUTY_STEP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CRPD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CRPD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/crpd_pkg.sv =====
// Types and constants of the current-regulated PWM duty stepper.
package crpd_pkg;

    localparam int NumLevels = 8;
    localparam int SelW      = $clog2(NumLevels);
    localparam int LevelW    = 4;
    localparam int AdcW      = 10;
    localparam int SetpointW = 10;
    localparam int DutyW     = 8;

    localparam logic [DutyW-1:0] PwmFloor       = 8'd20;
    localparam logic [DutyW-1:0] PwmCeil        = 8'd200;
    localparam logic [AdcW-1:0]  LowSupplyLimit = 10'h288;
    localparam logic [3:0]       RatioNum       = 4'd15;
    localparam logic [1:0]       DeadBand       = 2'd2;

    typedef enum logic [0:0] {
        OP_TICK   = 1'b0,
        OP_DISARM = 1'b1
    } op_t;

    typedef struct packed {
        op_t                 opcode;
        logic [LevelW-1:0]   level_index;
        logic [AdcW-1:0]     out_current;
        logic [AdcW-1:0]     in_current;
        logic [AdcW-1:0]     supply_sense_a;
        logic [AdcW-1:0]     supply_sense_b;
    } item_t;

    typedef struct packed {
        logic [DutyW-1:0] duty;
        logic             output_enabled;
    } result_t;

    typedef logic [NumLevels-1:0][SetpointW-1:0] setpoint_arr_t;

endpackage

// ===== rtl/current_regulated_pwm_duty_step.sv =====
// Top level of the current-regulated PWM duty stepper.
//
//  channel  dir  handshake           payload
//  s_       in   s_tvalid/s_tready   s_tuser opcode, s_tdata level and ADC samples
//  m_       out  m_tvalid/m_tready   m_tdata duty, output_enabled
//  cfg_     in   cfg_we              cfg_index, cfg_data (setpoint per level)
//
// One request per cycle while m_tready is high; each request yields one result via
// the input register, then the result register. The duty, armed and drive state
// is updated as a request moves from the input register into the result register.
// When m_tready is low both registers fill and s_tready drops; no request is lost.
// Reset sets the duty to its floor, disarms, turns the drive off, clears setpoints.
module current_regulated_pwm_duty_step (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [47:0]                    s_tdata,   // level_index, out_current,
                                                      // in_current, supply_sense_a,
                                                      // supply_sense_b, zero fill
    input  logic [0:0]                     s_tuser,   // opcode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,   // duty, output_enabled, zero fill
    input  logic                           cfg_we,
    input  logic [crpd_pkg::SelW-1:0]      cfg_index,
    input  logic [crpd_pkg::SetpointW-1:0] cfg_data
);
    import crpd_pkg::*;

    logic          in_valid_reg;
    item_t         in_item_reg;
    logic          out_valid_reg;
    result_t       out_result_reg;
    logic          advance;
    result_t       step_result;
    setpoint_arr_t setpoints;

    // The input register moves on whenever the result register is free or drains.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.opcode         <= op_t'(s_tuser[0]);
            in_item_reg.level_index    <= s_tdata[3:0];
            in_item_reg.out_current    <= s_tdata[13:4];
            in_item_reg.in_current     <= s_tdata[23:14];
            in_item_reg.supply_sense_a <= s_tdata[33:24];
            in_item_reg.supply_sense_b <= s_tdata[43:34];
        end
        if (advance)
        begin
            out_result_reg <= step_result;
        end
    end

    crpd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .setpoints (setpoints)
    );

    crpd_step_core u_step_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (advance),
        .item      (in_item_reg),
        .setpoints (setpoints),
        .result    (step_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_result_reg.output_enabled, out_result_reg.duty};

endmodule

// ===== rtl/crpd_cfg_regs.sv =====
// Setpoint register file, one current target for each power level.
module crpd_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [crpd_pkg::SelW-1:0]         cfg_index,
    input  logic [crpd_pkg::SetpointW-1:0]    cfg_data,
    output crpd_pkg::setpoint_arr_t           setpoints
);
    import crpd_pkg::*;

    setpoint_arr_t setpoint_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg <= '0;
        end
        else if (cfg_we)
        begin
            setpoint_reg[cfg_index] <= cfg_data;
        end
    end

    assign setpoints = setpoint_reg;

endmodule

// ===== rtl/crpd_step_core.sv =====
// Duty state and the one-step regulation logic for a single request.
`include "current_regulated_pwm_duty_step_assert.svh"

module crpd_step_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step_en,
    input  crpd_pkg::item_t         item,
    input  crpd_pkg::setpoint_arr_t setpoints,
    output crpd_pkg::result_t       result
);
    import crpd_pkg::*;

    logic [DutyW-1:0]     duty_value_reg;
    logic [DutyW-1:0]     duty_value_next;
    logic                 armed_reg;
    logic                 armed_next;
    logic                 drive_on_reg;
    logic                 drive_on_next;

    logic                 low_supply;
    logic [LevelW-1:0]    eff_level;
    logic [SetpointW-1:0] sp;
    logic [13:0]          ratio_lhs;
    logic [13:0]          ratio_rhs;
    logic                 ratio_trip;
    logic                 below_band;
    logic                 above_band;
    logic [DutyW-1:0]     duty_step;

    always_comb
    begin
        low_supply = (item.supply_sense_a <= LowSupplyLimit)
                  || (item.supply_sense_b <= LowSupplyLimit);

        // A low supply halves any nonzero level but never turns it off.
        eff_level = item.level_index;
        if (item.level_index != '0 && low_supply)
        begin
            eff_level = item.level_index >> 1;
            if (eff_level == '0)
            begin
                eff_level = LevelW'(1);
            end
        end

        sp = '0;
        if (eff_level != '0 && eff_level <= LevelW'(NumLevels))
        begin
            sp = setpoints[SelW'(eff_level - LevelW'(1))];
        end

        // Output at or above 3.75 times a nonzero input: out*4 >= 15*in.
        ratio_lhs  = {2'b00, item.out_current, 2'b00};
        ratio_rhs  = {4'b0000, item.in_current} * {10'b0, RatioNum};
        ratio_trip = (item.in_current != '0) && (ratio_lhs >= ratio_rhs);

        // Lower band edge may go negative for small setpoints.
        below_band = $signed({2'b00, item.out_current})
                   < ($signed({2'b00, sp}) - $signed({10'b0, DeadBand}));
        above_band = {1'b0, item.out_current} > ({1'b0, sp} + {9'b0, DeadBand});

        if (!armed_reg || ratio_trip)
        begin
            duty_step = duty_value_reg - DutyW'(1);
        end
        else if (below_band)
        begin
            duty_step = duty_value_reg + DutyW'(1);
        end
        else if (above_band)
        begin
            duty_step = duty_value_reg - DutyW'(1);
        end
        else
        begin
            duty_step = duty_value_reg;
        end

        duty_value_next = duty_value_reg;
        armed_next      = armed_reg;
        drive_on_next   = drive_on_reg;

        unique case (item.opcode)
            OP_DISARM:
            begin
                if (drive_on_reg)
                begin
                    armed_next = 1'b0;
                end
            end
            OP_TICK:
            begin
                if (eff_level == '0)
                begin
                    duty_value_next = PwmFloor;
                    drive_on_next   = 1'b0;
                end
                else
                begin
                    priority if (duty_step < PwmFloor)
                    begin
                        duty_value_next = PwmFloor;
                    end
                    else if (duty_step > PwmCeil)
                    begin
                        duty_value_next = PwmCeil;
                    end
                    else
                    begin
                        duty_value_next = duty_step;
                    end
                    armed_next    = 1'b1;
                    drive_on_next = 1'b1;
                end
            end
            default:
            begin
                duty_value_next = duty_value_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_value_reg <= PwmFloor;
            armed_reg      <= 1'b0;
            drive_on_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            duty_value_reg <= duty_value_next;
            armed_reg      <= armed_next;
            drive_on_reg   <= drive_on_next;
        end
    end

    assign result.duty           = duty_value_next;
    assign result.output_enabled = drive_on_next;

    `CRPD_ASSERT_IMP(a_duty_in_range, clk, rst_n, 1'b1, duty_value_reg >= PwmFloor && duty_value_reg <= PwmCeil, "duty left its range")
    `CRPD_ASSERT_NXT(a_disarm_clears, clk, rst_n, step_en && item.opcode == OP_DISARM && drive_on_reg, !armed_reg, "disarm with drive on did not clear armed")
    `CRPD_ASSERT_NXT(a_disarm_keeps_duty, clk, rst_n, step_en && item.opcode == OP_DISARM, $stable(duty_value_reg) && $stable(drive_on_reg), "disarm changed duty or drive")
    `CRPD_ASSERT_NXT(a_off_to_floor, clk, rst_n, step_en && item.opcode == OP_TICK && eff_level == '0, duty_value_reg == PwmFloor && !drive_on_reg, "level zero did not switch off")

endmodule
